// ----- design/dks_pkg.sv -----
`timescale 1ns / 1ps

package dks_pkg;

    localparam int MAX_ENTRIES = 32;
    localparam int KEY_BITS    = 12;
    localparam int TAG_BITS    = 6;
    localparam int ADDR_BITS   = $clog2(MAX_ENTRIES);
    localparam int CNT_BITS    = $clog2(MAX_ENTRIES + 1);
    localparam int TDATA_BITS  = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;
    localparam int PAD_BITS    = TDATA_BITS - KEY_BITS - TAG_BITS;

    typedef struct packed {
        logic [TAG_BITS-1:0] tag;
        logic [KEY_BITS-1:0] key;
    } record_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_EMIT_RD,
        ST_EMIT_LOAD
    } state_t;

endpackage

// ----- design/descending_key_sorter.sv -----
`timescale 1ns / 1ps

// A request into an empty store is written and one into a full store is dropped while idle;
// otherwise the insertion walks the store from its tail one record per cycle through the
// single compare unit. After the request marked last is stored or dropped, records leave from
// the head: each is read from memory (registered read), then loaded once the output register is free.
// Reset clears the sequencer, the fill count, the drop flag and the output valid flag; the
// record memory is not cleared, since only entries written in the current set are ever used.
module descending_key_sorter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: key, tag, zero padding.
    input  logic [dks_pkg::TDATA_BITS-1:0] s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: sorted_key, sorted_tag, zero padding.
    output logic [dks_pkg::TDATA_BITS-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    // Fields from bit 0: overflow.
    output logic                          m_axis_tuser
);

    dks_pkg::state_t                  state_reg, state_next;
    logic [dks_pkg::CNT_BITS-1:0]     fill_reg, fill_next;
    logic                             dropped_reg, dropped_next;
    logic                             last_reg, last_next;
    dks_pkg::record_t                 new_rec_reg, new_rec_next;
    logic [dks_pkg::ADDR_BITS-1:0]    idx_reg, idx_next;
    logic                             out_valid_reg, out_valid_next;
    dks_pkg::record_t                 out_rec_reg, out_rec_next;
    logic                             out_last_reg, out_last_next;
    logic                             out_ovf_reg, out_ovf_next;

    dks_pkg::record_t                 mem [dks_pkg::MAX_ENTRIES];
    dks_pkg::record_t                 rd_data_reg;
    logic [dks_pkg::ADDR_BITS-1:0]    rd_addr;
    logic [dks_pkg::ADDR_BITS-1:0]    wr_addr;
    dks_pkg::record_t                 wr_data;
    logic                             wr_en;

    logic                             in_fire;
    dks_pkg::record_t                 in_rec;
    logic                             store_full;
    logic                             store_empty;
    logic [dks_pkg::CNT_BITS-1:0]     fill_dec;
    logic [dks_pkg::ADDR_BITS-1:0]    idx_inc;
    logic [dks_pkg::ADDR_BITS-1:0]    idx_dec;
    logic                             shift_down;
    logic                             emit_last;
    logic                             out_free;

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign in_rec.key  = s_axis_tdata[dks_pkg::KEY_BITS-1:0];
    assign in_rec.tag  = s_axis_tdata[dks_pkg::KEY_BITS +: dks_pkg::TAG_BITS];
    assign store_full  = (fill_reg == dks_pkg::CNT_BITS'(dks_pkg::MAX_ENTRIES));
    assign store_empty = (fill_reg == '0);
    assign fill_dec    = fill_reg - dks_pkg::CNT_BITS'(1);
    assign idx_inc     = idx_reg + dks_pkg::ADDR_BITS'(1);
    assign idx_dec     = idx_reg - dks_pkg::ADDR_BITS'(1);
    assign shift_down  = (rd_data_reg.key < new_rec_reg.key);
    assign emit_last   = (fill_reg == (dks_pkg::CNT_BITS'(idx_reg) + dks_pkg::CNT_BITS'(1)));
    assign out_free    = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == dks_pkg::ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{dks_pkg::PAD_BITS{1'b0}}, out_rec_reg.tag, out_rec_reg.key};
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = out_ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dks_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (store_full || store_empty)
                    begin
                        state_next = s_axis_tlast ? dks_pkg::ST_EMIT_RD : dks_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = dks_pkg::ST_SCAN;
                    end
                end
            end
            dks_pkg::ST_SCAN:
            begin
                if (!shift_down)
                begin
                    state_next = last_reg ? dks_pkg::ST_EMIT_RD : dks_pkg::ST_IDLE;
                end
                else if (idx_reg == '0)
                begin
                    state_next = dks_pkg::ST_PLACE;
                end
            end
            dks_pkg::ST_PLACE:
            begin
                state_next = last_reg ? dks_pkg::ST_EMIT_RD : dks_pkg::ST_IDLE;
            end
            dks_pkg::ST_EMIT_RD:
            begin
                if (out_free)
                begin
                    state_next = dks_pkg::ST_EMIT_LOAD;
                end
            end
            dks_pkg::ST_EMIT_LOAD:
            begin
                state_next = emit_last ? dks_pkg::ST_IDLE : dks_pkg::ST_EMIT_RD;
            end
            default:
            begin
                state_next = dks_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_next      = fill_reg;
        dropped_next   = dropped_reg;
        last_next      = last_reg;
        new_rec_next   = new_rec_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_rec_next   = out_rec_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        rd_addr        = idx_reg;
        wr_addr        = '0;
        wr_data        = new_rec_reg;
        wr_en          = 1'b0;
        case (state_reg)
            dks_pkg::ST_IDLE:
            begin
                rd_addr = fill_dec[dks_pkg::ADDR_BITS-1:0];
                if (in_fire)
                begin
                    last_next    = s_axis_tlast;
                    new_rec_next = in_rec;
                    idx_next     = fill_dec[dks_pkg::ADDR_BITS-1:0];
                    if (store_full)
                    begin
                        dropped_next = 1'b1;
                        idx_next     = '0;
                    end
                    else if (store_empty)
                    begin
                        wr_en     = 1'b1;
                        wr_data   = in_rec;
                        fill_next = dks_pkg::CNT_BITS'(1);
                        idx_next  = '0;
                    end
                end
            end
            dks_pkg::ST_SCAN:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_inc;
                rd_addr = idx_dec;
                if (shift_down)
                begin
                    wr_data = rd_data_reg;
                    if (idx_reg != '0)
                    begin
                        idx_next = idx_dec;
                    end
                end
                else
                begin
                    wr_data   = new_rec_reg;
                    fill_next = fill_reg + dks_pkg::CNT_BITS'(1);
                    idx_next  = '0;
                end
            end
            dks_pkg::ST_PLACE:
            begin
                wr_en     = 1'b1;
                wr_addr   = '0;
                wr_data   = new_rec_reg;
                fill_next = fill_reg + dks_pkg::CNT_BITS'(1);
                idx_next  = '0;
            end
            dks_pkg::ST_EMIT_RD:
            begin
                rd_addr = idx_reg;
            end
            dks_pkg::ST_EMIT_LOAD:
            begin
                out_valid_next = 1'b1;
                out_rec_next   = rd_data_reg;
                out_last_next  = emit_last;
                out_ovf_next   = dropped_reg;
                if (emit_last)
                begin
                    fill_next    = '0;
                    dropped_next = 1'b0;
                    idx_next     = '0;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end
            default:
            begin
                rd_addr = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dks_pkg::ST_IDLE;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            last_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            last_reg      <= last_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_rec_reg  <= new_rec_next;
        out_rec_reg  <= out_rec_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= dks_pkg::CNT_BITS'(dks_pkg::MAX_ENTRIES))
        else $error("fill count exceeds store capacity");

    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dks_pkg::ST_EMIT_LOAD) |-> !out_valid_reg)
        else $error("output register loaded while a request is pending");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dks_pkg::ST_SCAN) |->
            (!store_full && (dks_pkg::CNT_BITS'(idx_reg) < fill_reg)))
        else $error("scan index outside the filled store");

    a_drop_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && store_full) |=> dropped_reg)
        else $error("dropped request did not set the drop flag");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dks_pkg::ST_EMIT_RD) |-> !store_empty)
        else $error("emission started on an empty store");
`endif

endmodule
